### design/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg: shared types and constants for the button edge / auto-repeat block
// Holds the sizing constants, the hold-count cell record, the remainder unit
// status record, the register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int BTN_CNT = 16;                 // buttons with a hold counter
  localparam int WORD_W  = 16;                 // width of the button word
  localparam int CNT_W   = 8;                  // hold counter width
  localparam int IDX_W   = (BTN_CNT > 1) ? $clog2(BTN_CNT) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX       = '1;
  localparam logic [CNT_W-1:0] DELAY_RESET   = CNT_W'(18);
  localparam logic [CNT_W-1:0] PERIOD_RESET  = CNT_W'(5);
  localparam int               MOD_STEPS     = CNT_W;
  localparam int               MOD_CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef enum logic {
    REG_DELAY  = 1'b0,
    REG_PERIOD = 1'b1
  } bae_reg_t;

  typedef struct packed {
    logic             held;
    logic [CNT_W-1:0] count;
  } bae_cell_t;

  typedef struct packed {
    logic done;
    logic zero;
  } bae_mod_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_WAIT,
    S_OUT
  } bae_state_t;

endpackage

### design/bae_cell.sv
// ----------------------------------------------------------------------------
// bae_cell: one hold-count cell of the rotating ring
// Updates its counter from the new button level when a frame is taken, and
// otherwise takes its neighbor's contents when the ring advances.
// ----------------------------------------------------------------------------
module bae_cell
  import bae_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      upd,
  input  logic      held_in,
  input  logic      shift,
  input  bae_cell_t nbr,
  output bae_cell_t q
);

  bae_cell_t cell_r, cell_nxt;

  always_comb begin
    cell_nxt = cell_r;
    if (upd) begin
      cell_nxt.held = held_in;
      if (!held_in) begin
        cell_nxt.count = '0;
      end else if (cell_r.count != CNT_MAX) begin
        cell_nxt.count = cell_r.count + CNT_W'(1);
      end
    end else if (shift) begin
      cell_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign q = cell_r;

endmodule

### design/bae_mod.sv
// ----------------------------------------------------------------------------
// bae_mod: iterative remainder unit
// Restoring remainder of an 8-bit dividend by an 8-bit nonzero divisor, one
// dividend bit per cycle; reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module bae_mod
  import bae_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output bae_mod_res_t     res
);

  logic                 busy_r, busy_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     x_r, x_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W:0]       trial;
  logic [CNT_W-1:0]     rem_step;
  logic                 last;

  always_comb begin
    trial = {rem_r, x_r[CNT_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_step = CNT_W'(trial - {1'b0, divisor});
    end else begin
      rem_step = trial[CNT_W-1:0];
    end
    last = busy_r && (cnt_r == MOD_CNT_W'(MOD_STEPS - 1));

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      x_nxt   = {x_r[CNT_W-2:0], 1'b0};
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = last;
  assign res.zero = (rem_step == '0);

endmodule

### design/button_edge_and_autorepeat_top.sv
// ----------------------------------------------------------------------------
// button_edge_and_autorepeat_top: button edge detector with auto-repeat
// Reports held, newly pressed, newly released and auto-repeat masks for one
// sampled button word per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_buttons carries one button word per
//   request. Result channel out_valid/out_ready carries the four masks.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while idle:
//   index 0 is the repeat delay, index 1 the repeat period (0 acts as 1).
//   A request updates all hold counters in the cycle it is taken. The
//   counters then rotate once around a ring of cells; the head cell is
//   checked each step. A button below the delay or released takes a single
//   step; a held button at or past the delay also waits for the bit-serial
//   remainder unit, which must finish before the ring advances. One request
//   is in flight at a time and in_ready is high only when idle.
//   The result sits in an output register, so a new request is taken while
//   it waits; if the receiver still stalls when the next result is done,
//   the block holds in its last step until the output register frees.
//   Reset clears previous buttons, all hold counts and the registers to
//   delay 18 and period 5.
// ----------------------------------------------------------------------------
module button_edge_and_autorepeat_top
  import bae_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_buttons,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_held_mask,
  output logic [WORD_W-1:0] out_pressed_mask,
  output logic [WORD_W-1:0] out_released_mask,
  output logic [WORD_W-1:0] out_repeat_mask,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  bae_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  delay_r, period_r;
  logic [WORD_W-1:0] prev_r;
  logic [WORD_W-1:0] held_r, pressed_r, released_r;
  logic [BTN_CNT-1:0] rep_r;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic              out_valid_r;

  logic              accept;
  logic              shift;
  logic              hit;
  logic              mod_start;
  logic              load_out;
  logic              eligible;
  logic              last_step;
  logic [CNT_W-1:0]  period_eff;
  logic [CNT_W-1:0]  offset;
  logic [WORD_W-1:0] rep_word;
  bae_cell_t         cell_q [BTN_CNT];
  bae_mod_res_t      mod_res;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // ring of hold-count cells; the head feeds the tail
  for (genvar i = 0; i < BTN_CNT; i++) begin : g_cell
    logic held_bit;
    if (i < WORD_W) begin : g_in
      assign held_bit = in_buttons[i];
    end else begin : g_none
      assign held_bit = 1'b0;
    end
    bae_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (accept),
      .held_in (held_bit),
      .shift   (shift),
      .nbr     (cell_q[(i + 1) % BTN_CNT]),
      .q       (cell_q[i])
    );
  end

  assign period_eff = (period_r == '0) ? CNT_W'(1) : period_r;
  assign eligible   = cell_q[0].held && (cell_q[0].count >= delay_r);
  assign offset     = cell_q[0].count - delay_r;
  assign last_step  = (step_r == IDX_W'(BTN_CNT - 1));

  bae_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (offset),
    .divisor  (period_eff),
    .res      (mod_res)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    shift     = 1'b0;
    hit       = 1'b0;
    mod_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          step_nxt  = '0;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (eligible) begin
          mod_start = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          shift     = 1'b1;
          step_nxt  = step_r + IDX_W'(1);
          state_nxt = last_step ? S_OUT : S_HEAD;
        end
      end
      S_WAIT: begin
        if (mod_res.done) begin
          hit       = mod_res.zero;
          shift     = 1'b1;
          step_nxt  = step_r + IDX_W'(1);
          state_nxt = last_step ? S_OUT : S_HEAD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      delay_r     <= DELAY_RESET;
      period_r    <= PERIOD_RESET;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        case (bae_reg_t'(cfg_index))
          REG_DELAY:  delay_r  <= cfg_wdata;
          REG_PERIOD: period_r <= cfg_wdata;
          default:    delay_r  <= delay_r;
        endcase
      end
      if (accept) begin
        prev_r <= in_buttons;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // repeat bits shift in behind the ring so bit k lands at position k
  for (genvar j = 0; j < WORD_W; j++) begin : g_rep
    if (j < BTN_CNT) begin : g_bit
      assign rep_word[j] = rep_r[j];
    end else begin : g_zero
      assign rep_word[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r     <= in_buttons;
      pressed_r  <= in_buttons & ~prev_r;
      released_r <= prev_r & ~in_buttons;
      rep_r      <= '0;
    end else if (shift) begin
      if (BTN_CNT > 1) begin
        rep_r <= {hit, rep_r[BTN_CNT-1:1]};
      end else begin
        rep_r <= BTN_CNT'(hit);
      end
    end
    if (load_out) begin
      out_held_mask     <= held_r;
      out_pressed_mask  <= pressed_r;
      out_released_mask <= released_r;
      out_repeat_mask   <= pressed_r | rep_word;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_HEAD) && (step_r == '0) && (rep_r == '0))
    else $error("request did not restart the ring walk");

  a_repeat_has_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_pressed_mask & ~out_repeat_mask) == '0))
    else $error("new press missing from repeat mask");

  a_held_vs_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_held_mask & out_released_mask) == '0))
    else $error("button both held and released");

  a_mod_only_head: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start |=> (state_r == S_WAIT))
    else $error("remainder started outside head step");

endmodule

### verif/button_edge_and_autorepeat_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_edge_and_autorepeat_top_test: frame-level check of the edge/repeat block
// Drives button words through the valid/ready request channel and predicts the
// held, pressed, released and repeat masks from its own hold counters. Each
// result is compared with the oldest prediction. Covers several delay/period
// settings, counter saturation, random stalls on both sides and a long output
// hold-off.
// ----------------------------------------------------------------------------
module button_edge_and_autorepeat_top_test;
  import bae_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int END_CYCLES      = 200;
  localparam int REPORT_MAX      = 10;

  typedef struct packed {
    logic [WORD_W-1:0] held;
    logic [WORD_W-1:0] pressed;
    logic [WORD_W-1:0] released;
    logic [WORD_W-1:0] rpt;
  } masks_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] in_buttons;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_held_mask;
  logic [WORD_W-1:0] out_pressed_mask;
  logic [WORD_W-1:0] out_released_mask;
  logic [WORD_W-1:0] out_repeat_mask;
  logic              cfg_we;
  logic              cfg_index;
  logic [CNT_W-1:0]  cfg_wdata;

  // predictor state
  logic [WORD_W-1:0] prev_word = '0;
  logic [CNT_W-1:0]  hold_cnt [BTN_CNT] = '{default: '0};
  logic [CNT_W-1:0]  delay_reg  = DELAY_RESET;
  logic [CNT_W-1:0]  period_reg = PERIOD_RESET;

  masks_t pending_masks [$];
  int     mismatch_cnt = 0;
  int     burst_left   = 0;
  bit     hold_off_req = 1'b0;

  button_edge_and_autorepeat_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_buttons        (in_buttons),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_held_mask     (out_held_mask),
    .out_pressed_mask  (out_pressed_mask),
    .out_released_mask (out_released_mask),
    .out_repeat_mask   (out_repeat_mask),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // Advance the hold counters for one frame and build the four masks.
  function automatic masks_t predict_masks(input logic [WORD_W-1:0] now);
    masks_t      m;
    int unsigned n;
    int unsigned per;
    m.held     = now;
    m.pressed  = now & ~prev_word;
    m.released = prev_word & ~now;
    m.rpt      = m.pressed;
    per = (period_reg == 0) ? 32'd1 : 32'(period_reg);
    for (int i = 0; i < BTN_CNT; i++) begin
      if (now[i]) begin
        n = 32'(hold_cnt[i]);
        if (n < CNT_MAX) n++;
        hold_cnt[i] = n[CNT_W-1:0];
        if (n >= delay_reg && ((n - delay_reg) % per) == 0) m.rpt[i] = 1'b1;
      end else begin
        hold_cnt[i] = '0;
      end
    end
    prev_word = now;
    return m;
  endfunction

  // Flip each button with a chance of one in odds.
  function automatic logic [WORD_W-1:0] drift(input logic [WORD_W-1:0] cur, input int odds);
    logic [WORD_W-1:0] w;
    w = cur;
    for (int i = 0; i < WORD_W; i++) begin
      if ($urandom_range(0, odds - 1) == 0) w[i] = ~w[i];
    end
    return w;
  endfunction

  // Offer one request; bursts of random length with random gaps in between.
  task automatic send_frame(input logic [WORD_W-1:0] word);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_buttons <= word;
    do @(posedge clk); while (!in_ready);
    pending_masks.push_back(predict_masks(word));
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_masks.size() != 0) @(posedge clk);
  endtask

  task automatic set_repeat(input logic [CNT_W-1:0] delay_val,
                            input logic [CNT_W-1:0] period_val);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DELAY;
    cfg_wdata <= delay_val;
    @(negedge clk);
    cfg_index <= REG_PERIOD;
    cfg_wdata <= period_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    delay_reg  = delay_val;
    period_reg = period_val;
  endtask

  task automatic test_reset_defaults();
    send_frame(16'h0000);
    send_frame(16'hFFFF);
    send_frame(16'h0000);
    send_frame(16'hAAAA);
    send_frame(16'h5555);
    // hold everything past the default delay to see the first repeats
    repeat (20) send_frame(16'hFFFF);
  endtask

  task automatic test_config_extremes();
    logic [CNT_W-1:0]  delays  [6] = '{8'd1, 8'd255, 8'd1, 8'd255, 8'd0, 8'd0};
    logic [CNT_W-1:0]  periods [6] = '{8'd1, 8'd255, 8'd255, 8'd1, 8'd0, 8'd3};
    logic [WORD_W-1:0] words   [7] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                                       16'h5555, 16'h5555, 16'hFFFF};
    for (int s = 0; s < 6; s++) begin
      set_repeat(delays[s], periods[s]);
      foreach (words[k]) send_frame(words[k]);
      send_frame(WORD_W'($urandom));
    end
  endtask

  // Keep two buttons down long enough to pin their counters at the top.
  task automatic test_count_saturation();
    logic [WORD_W-1:0] word;
    word = '0;
    set_repeat(8'd200, 8'd20);
    repeat (140) begin
      word = drift(word, 24) | 16'h8001;
      send_frame(word);
    end
    set_repeat(8'd255, 8'd1);
    repeat (130) begin
      word = drift(word, 24) | 16'h8001;
      send_frame(word);
    end
    set_repeat(8'd250, 8'd3);
    repeat (10) begin
      word = drift(word, 24) | 16'h8001;
      send_frame(word);
    end
  endtask

  task automatic test_random_frames();
    logic [WORD_W-1:0] word;
    int                odds;
    word = '0;
    for (int ph = 0; ph < 4; ph++) begin
      set_repeat(CNT_W'($urandom_range(0, 40)), CNT_W'($urandom_range(0, 12)));
      odds = $urandom_range(3, 40);
      repeat (25) begin
        if ($urandom_range(0, 9) == 0) word = WORD_W'($urandom);
        else word = drift(word, odds);
        send_frame(word);
      end
    end
  endtask

  // Hold the output off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    logic [WORD_W-1:0] word;
    word = 16'h0F0F;
    set_repeat(8'd2, 8'd1);
    hold_off_req = 1'b1;
    repeat (16) begin
      word = drift(word, 6);
      send_frame(word);
    end
  endtask

  initial begin : result_stall
    int run_left;
    out_ready = 1'b0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
        run_left = 8;
      end else if (run_left > 0) begin
        run_left--;
      end else if (out_ready) begin
        out_ready <= 1'b0;
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
        run_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin : frame_check
    masks_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_masks.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t: result with no request pending: held=%h pressed=%h released=%h rpt=%h",
                   $realtime, out_held_mask, out_pressed_mask, out_released_mask,
                   out_repeat_mask);
      end else begin
        want = pending_masks.pop_front();
        if (out_held_mask !== want.held || out_pressed_mask !== want.pressed ||
            out_released_mask !== want.released || out_repeat_mask !== want.rpt) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t: mask mismatch, expected held=%h pressed=%h released=%h rpt=%h",
                     $realtime, want.held, want.pressed, want.released, want.rpt);
            $display("%0t:                  actual held=%h pressed=%h released=%h rpt=%h",
                     $realtime, out_held_mask, out_pressed_mask, out_released_mask,
                     out_repeat_mask);
          end
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_buttons = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_DELAY;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_count_saturation();
    test_random_frames();
    test_backpressure();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_masks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### button_edge_and_autorepeat_top.f
design/bae_pkg.sv
design/bae_cell.sv
design/bae_mod.sv
design/button_edge_and_autorepeat_top.sv
verif/button_edge_and_autorepeat_top_test.sv
